### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Types and constants of the FIFO queue with membership search.
// ----------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 5;
   localparam int DATA_W = 32;

   localparam logic [1:0] MODE_ENQ        = 2'd0;
   localparam logic [1:0] MODE_DEQ        = 2'd1;
   localparam logic [1:0] MODE_SEARCH     = 2'd2;
   localparam logic [1:0] MODE_ENQ_ABSENT = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DUP   = 2'd3;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic               found;
      logic [CNT_W-1:0]   count;
      logic               is_empty;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic issue_done;
      logic pending;
   } ctl_status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } ctl_state_type;

endpackage

`default_nettype wire

### rtl/fqs_ram.sv
// ----------------------------------------------------------------------------
// fqs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/fqs_ctrl.sv
// ----------------------------------------------------------------------------
// fqs_ctrl
// Sequencer: load a transaction, scan the live entries, commit the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire fqs_pkg::ctl_status_type sts,
   output      fqs_pkg::ctl_cmd_type    cmd,
   output      logic                    busy
);

   import fqs_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = !sts.issue_done;
            if (sts.issue_done && !sts.pending) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

### rtl/fqs_datapath.sv
// ----------------------------------------------------------------------------
// fqs_datapath
// Ring pointers, entry memory, key compare and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fqs_pkg::req_type         req_data,
   input  wire fqs_pkg::ctl_cmd_type     cmd,
   output      fqs_pkg::ctl_status_type  sts,
   output      logic                     rsp_valid,
   output      fqs_pkg::rsp_type         rsp_data
);

   import fqs_pkg::*;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              cmp_vld_ff;
   logic              cmp_first_ff;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] head_data_ff, head_data_in;
   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              wr_en;
   logic              do_push;

   assign rd_addr = head_ff + rd_idx_ff[IDX_W-1:0];

   fqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_ff.value),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.issue_done = (rd_idx_ff == count_ff);
   assign sts.pending    = cmp_vld_ff;

   always_comb begin
      found_in     = found_ff;
      head_data_in = head_data_ff;
      rd_idx_in    = rd_idx_ff;
      if (cmd.load) begin
         found_in  = 1'b0;
         rd_idx_in = '0;
      end else begin
         if (cmp_vld_ff && (rd_data == req_ff.value)) begin
            found_in = 1'b1;
         end
         if (cmp_vld_ff && cmp_first_ff) begin
            head_data_in = rd_data;
         end
         if (cmd.issue) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      do_push         = 1'b0;
      rsp_in.status   = ST_OK;
      rsp_in.data_out = '0;
      rsp_in.found    = found_ff;
      case (req_ff.mode)
         MODE_ENQ: begin
            if (count_ff == FULL_COUNT) begin
               rsp_in.status = ST_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         MODE_DEQ: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.data_out = head_data_ff;
               head_in         = head_ff + IDX_W'(1);
               count_in        = count_ff - CNT_W'(1);
            end
         end
         MODE_SEARCH: begin
         end
         default: begin
            if (found_ff) begin
               rsp_in.status = ST_DUP;
            end else if (count_ff == FULL_COUNT) begin
               rsp_in.status = ST_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
      endcase
      if (do_push) begin
         tail_in  = tail_ff + IDX_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
      rsp_in.count    = count_in;
      rsp_in.is_empty = (count_in == '0);
   end

   assign wr_en = cmd.commit && do_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_vld_ff   <= cmd.issue;
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      cmp_first_ff <= cmd.issue && (rd_idx_ff == '0);
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      head_data_ff <= head_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/fifo_queue_with_search_unit.sv
// Each transaction scans all live entries, one per cycle, before the result strobe;
// an empty queue has no entries to scan. Transactions are handled one at a time;
// busy is high from accept until commit, and a new start is taken on the strobe cycle.
// Reset clears pointers and count; entry contents stay undefined until written.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// FIFO queue of signed 32-bit values with membership search and
// enqueue-if-absent.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_search_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire fqs_pkg::req_type req_data,
   output      logic             rsp_valid,
   output      fqs_pkg::rsp_type rsp_data
);

   import fqs_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type sts;

   fqs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   fqs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/fqs_checker.sv
// ----------------------------------------------------------------------------
// fqs_checker
// Port-level checks of the FIFO queue with membership search.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fqs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire fqs_pkg::rsp_type rsp_data
);

   import fqs_pkg::*;

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_count_range, clock, reset, rsp_valid, rsp_data.count <= FULL_COUNT)
   `ASSERT_IMPLIES(a_empty_flag, clock, reset, rsp_valid, rsp_data.is_empty == (rsp_data.count == '0))
   `ASSERT_IMPLIES(a_err_no_data, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.data_out == '0)
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind fifo_queue_with_search_unit fqs_checker u_fqs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
